// ----- hw/rtl/mfdm_pkg.sv -----
// Shared types and constants for the motor feedback decoder.
package mfdm_pkg;

	localparam int unsigned ACC_W      = 43;
	localparam int unsigned QUOT_W     = 26;
	localparam int unsigned RED_STEPS  = 5;
	localparam int unsigned TDATA_IN_W = 80;
	localparam int unsigned TDATA_OUT_W = 192;

	localparam logic [1:0] REG_ID_BASE  = 2'd0;
	localparam logic [1:0] REG_POS_MAX  = 2'd1;
	localparam logic [1:0] REG_VEL_MAX  = 2'd2;
	localparam logic [1:0] REG_TOR_MAX  = 2'd3;

	localparam logic [10:0] ID_BASE_RST = 11'd0;
	localparam logic [23:0] POS_MAX_RST = 24'd819200;
	localparam logic [23:0] VEL_MAX_RST = 24'd1966080;
	localparam logic [23:0] TOR_MAX_RST = 24'd655360;

	localparam logic signed [16:0] HALF_RANGE = 17'sd32768;
	localparam logic signed [15:0] TURN_MAX   = 16'sh7FFF;
	localparam logic signed [15:0] TURN_MIN   = 16'sh8000;

	localparam logic ACT_FRAME = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		AOP_HOLD = 2'd0,
		AOP_MUL  = 2'd1,
		AOP_RED  = 2'd2
	} aop_t;

	typedef enum logic [1:0] {
		FLD_POS = 2'd0,
		FLD_VEL = 2'd1,
		FLD_TOR = 2'd2
	} fld_t;

	typedef struct packed {
		aop_t op;
		logic wide;
		logic first;
	} arith_ctl_t;

endpackage

// ----- hw/rtl/motor_feedback_decode_multiturn_top.sv -----
// Top level of the motor feedback frame decoder with multi-turn tracking.
//
// Input stream: s_tvalid/s_tready, s_tdata carries frame_id and payload,
// s_tuser selects a feedback frame (0) or a turn-count clear (1).
// Output stream: m_tvalid/m_tready, one result item per input item,
// m_tuser flags an identifier that maps to no motor.
// Configuration: cfg_we writes cfg_data to register cfg_index at once.
// An item is taken only while the sequencer is idle. A feedback frame goes
// from acceptance to the result register through a lookup, then
// three scalings (multiply, five reduction steps, offset) on the
// shared multiply/reduce unit, a total-angle multiply and add, and the
// result load. A clear or an unknown identifier goes from the lookup
// straight to the result load. Input is accepted again in the cycle after
// the result is loaded, so no new item is taken before the last one is loaded.
// The result register holds an item while m_tready is low; the next item is
// worked on meanwhile and waits for the register before it is loaded.
// Reset sets the configuration registers to their defaults and clears the
// per-motor positions, turn counts and frame counts, and the output valid.
module motor_feedback_decode_multiturn_top #(
	parameter int MOTOR_COUNT = 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// frame_id[10:0], payload[74:11], zero pad[79:75]
	input  logic [mfdm_pkg::TDATA_IN_W-1:0]      s_tdata,
	// action[0]
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// motor_index[3:0], fault_state[7:4], position[32:8], velocity[57:33],
	// torque[82:58], total_angle[124:83], turns[140:125],
	// mos_temperature[148:141], rotor_temperature[156:149],
	// frames_seen[188:157], zero pad[191:189]
	output logic [mfdm_pkg::TDATA_OUT_W-1:0]     m_tdata,
	// id_error[0]
	output logic                                 m_tuser,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [23:0]                          cfg_data
);
	import mfdm_pkg::*;

	localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
	localparam logic [10:0] MOTOR_COUNT_ID = 11'(MOTOR_COUNT);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_LOOKUP = 8'b0000_0010,
		ST_MUL    = 8'b0000_0100,
		ST_RED    = 8'b0000_1000,
		ST_FIX    = 8'b0001_0000,
		ST_TMUL   = 8'b0010_0000,
		ST_TADD   = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [10:0]        id_base_q;
	logic [23:0]        pos_max_q;
	logic [23:0]        vel_max_q;
	logic [23:0]        tor_max_q;

	logic [15:0]        prev_pos_q [MOTOR_COUNT];
	logic signed [15:0] turn_q     [MOTOR_COUNT];
	logic [31:0]        frame_cnt_q [MOTOR_COUNT];

	logic               act_q;
	logic [10:0]        idx_q;
	logic [63:0]        payload_q;
	fld_t               fsel_q;
	logic [2:0]         step_q;

	logic               res_err_q;
	logic [3:0]         res_midx_q;
	logic [3:0]         res_fault_q;
	logic signed [24:0] res_pos_q;
	logic signed [24:0] res_vel_q;
	logic signed [24:0] res_tor_q;
	logic signed [41:0] res_total_q;
	logic signed [15:0] res_turns_q;
	logic [7:0]         res_mos_q;
	logic [7:0]         res_rotor_q;
	logic [31:0]        res_frames_q;

	logic                      m_tvalid_q;
	logic [TDATA_OUT_W-1:0]    m_tdata_q;
	logic                      m_tuser_q;

	logic                      in_acc;
	logic                      out_free;
	logic [MIDX_W-1:0]         midx;
	logic                      id_bad;
	logic [15:0]               praw;
	logic [11:0]               vraw;
	logic [11:0]               traw;
	logic signed [16:0]        pdiff;
	logic signed [15:0]        t_cur;
	logic signed [15:0]        t_new;

	arith_ctl_t                actl;
	logic signed [16:0]        mul_a;
	logic signed [25:0]        mul_b;
	logic [23:0]               lim;
	logic [ACC_W-1:0]          acc;
	logic signed [24:0]        scaled;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign midx   = idx_q[MIDX_W-1:0];
	assign id_bad = (idx_q >= MOTOR_COUNT_ID);
	assign praw   = payload_q[55:40];
	assign vraw   = payload_q[39:28];
	assign traw   = payload_q[27:16];
	assign pdiff  = $signed({1'b0, praw}) - $signed({1'b0, prev_pos_q[midx]});
	assign t_cur  = turn_q[midx];

	always_comb begin
		t_new = t_cur;
		priority if (pdiff < -HALF_RANGE) begin
			if (t_cur != TURN_MAX) t_new = t_cur + 16'sd1;
		end else if (pdiff > HALF_RANGE) begin
			if (t_cur != TURN_MIN) t_new = t_cur - 16'sd1;
		end else begin
			t_new = t_cur;
		end
	end

	always_comb begin
		actl.op    = AOP_HOLD;
		actl.wide  = (fsel_q == FLD_POS);
		actl.first = (step_q == 3'd0);
		mul_a      = $signed({1'b0, praw});
		mul_b      = $signed({1'b0, pos_max_q, 1'b0});
		lim        = pos_max_q;
		unique case (fsel_q)
			FLD_VEL: begin
				mul_a = $signed({5'b0, vraw});
				mul_b = $signed({1'b0, vel_max_q, 1'b0});
				lim   = vel_max_q;
			end
			FLD_TOR: begin
				mul_a = $signed({5'b0, traw});
				mul_b = $signed({1'b0, tor_max_q, 1'b0});
				lim   = tor_max_q;
			end
			default: begin
				mul_a = $signed({1'b0, praw});
			end
		endcase
		unique case (state_q)
			ST_MUL: actl.op = AOP_MUL;
			ST_RED: actl.op = AOP_RED;
			ST_TMUL: begin
				actl.op = AOP_MUL;
				mul_a   = 17'(res_turns_q);
				mul_b   = $signed({1'b0, pos_max_q, 1'b0});
			end
			default: actl.op = AOP_HOLD;
		endcase
	end

	mfdm_arith u_arith (
		.clk    (clk),
		.ctl    (actl),
		.mul_a  (mul_a),
		.mul_b  (mul_b),
		.lim    (lim),
		.acc    (acc),
		.scaled (scaled)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q <= ID_BASE_RST;
			pos_max_q <= POS_MAX_RST;
			vel_max_q <= VEL_MAX_RST;
			tor_max_q <= TOR_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ID_BASE: id_base_q <= cfg_data[10:0];
				REG_POS_MAX: pos_max_q <= cfg_data;
				REG_VEL_MAX: vel_max_q <= cfg_data;
				REG_TOR_MAX: tor_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				prev_pos_q[i]  <= '0;
				turn_q[i]      <= '0;
				frame_cnt_q[i] <= '0;
			end
		end else if (state_q == ST_LOOKUP && !id_bad) begin
			if (act_q == ACT_CLEAR) begin
				turn_q[midx] <= '0;
			end else begin
				turn_q[midx]      <= t_new;
				prev_pos_q[midx]  <= praw;
				frame_cnt_q[midx] <= frame_cnt_q[midx] + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fsel_q     <= FLD_POS;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: begin
					fsel_q <= FLD_POS;
					if (id_bad || act_q == ACT_CLEAR) state_q <= ST_OUT;
					else state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q  <= '0;
					state_q <= ST_RED;
				end
				ST_RED: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'(RED_STEPS - 1)) state_q <= ST_FIX;
				end
				ST_FIX: begin
					unique case (fsel_q)
						FLD_POS: begin
							fsel_q  <= FLD_VEL;
							state_q <= ST_MUL;
						end
						FLD_VEL: begin
							fsel_q  <= FLD_TOR;
							state_q <= ST_MUL;
						end
						default: state_q <= ST_TMUL;
					endcase
				end
				ST_TMUL: state_q <= ST_TADD;
				ST_TADD: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					act_q        <= s_tuser;
					idx_q        <= s_tdata[10:0] - id_base_q;
					payload_q    <= s_tdata[74:11];
					res_err_q    <= 1'b0;
					res_midx_q   <= '0;
					res_fault_q  <= '0;
					res_pos_q    <= '0;
					res_vel_q    <= '0;
					res_tor_q    <= '0;
					res_total_q  <= '0;
					res_turns_q  <= '0;
					res_mos_q    <= '0;
					res_rotor_q  <= '0;
					res_frames_q <= '0;
				end
			end
			ST_LOOKUP: begin
				if (id_bad) begin
					res_err_q <= 1'b1;
				end else if (act_q == ACT_CLEAR) begin
					res_midx_q   <= idx_q[3:0];
					res_frames_q <= frame_cnt_q[midx];
				end else begin
					res_midx_q   <= idx_q[3:0];
					res_fault_q  <= payload_q[63:60];
					res_turns_q  <= t_new;
					res_mos_q    <= payload_q[15:8];
					res_rotor_q  <= payload_q[7:0];
					res_frames_q <= frame_cnt_q[midx] + 32'd1;
				end
			end
			ST_FIX: begin
				unique case (fsel_q)
					FLD_POS: res_pos_q <= scaled;
					FLD_VEL: res_vel_q <= scaled;
					default: res_tor_q <= scaled;
				endcase
			end
			ST_TADD: begin
				res_total_q <= $signed(acc[41:0]) + 42'(res_pos_q);
			end
			ST_OUT: begin
				if (out_free) begin
					m_tuser_q <= res_err_q;
					m_tdata_q <= {3'b000, res_frames_q, res_rotor_q, res_mos_q,
						res_turns_q, res_total_q, res_tor_q, res_vel_q, res_pos_q,
						res_fault_q, res_midx_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ----- hw/rtl/mfdm_arith.sv -----
// Shared multiplier and divide-by-all-ones reduction unit.
module mfdm_arith (
	input  logic                            clk,
	input  mfdm_pkg::arith_ctl_t            ctl,
	input  logic signed [16:0]              mul_a,
	input  logic signed [25:0]              mul_b,
	input  logic [23:0]                     lim,
	output logic [mfdm_pkg::ACC_W-1:0]      acc,
	output logic signed [24:0]              scaled
);
	import mfdm_pkg::*;

	logic [ACC_W-1:0]         x_q;
	logic [QUOT_W-1:0]        q_q;
	logic signed [ACC_W-1:0]  prod;
	logic [ACC_W-1:0]         hi;
	logic [ACC_W-1:0]         lo;
	logic [ACC_W-1:0]         half;
	logic [ACC_W-1:0]         den;
	logic [QUOT_W-1:0]        quot;
	logic signed [QUOT_W:0]   diff;

	assign prod = ACC_W'(mul_a * mul_b);
	assign hi   = ctl.wide ? (x_q >> 16) : (x_q >> 12);
	assign lo   = ctl.wide ? (x_q & ACC_W'(16'hFFFF)) : (x_q & ACC_W'(12'hFFF));
	assign half = ctl.wide ? ACC_W'(15'h7FFF) : ACC_W'(11'h7FF);
	assign den  = ctl.wide ? ACC_W'(16'hFFFF) : ACC_W'(12'hFFF);

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			AOP_MUL: begin
				x_q <= prod;
				q_q <= '0;
			end
			AOP_RED: begin
				x_q <= hi + lo + (ctl.first ? half : '0);
				q_q <= q_q + hi[QUOT_W-1:0];
			end
			default: begin
				x_q <= x_q;
				q_q <= q_q;
			end
		endcase
	end

	assign quot   = q_q + QUOT_W'(x_q == den);
	assign diff   = $signed({1'b0, quot}) - $signed({3'b000, lim});
	assign acc    = x_q;
	assign scaled = diff[24:0];

endmodule
